>>> hdl/btpc_pkg.sv
// Package: shared constants and helpers for the barometric compensation unit.
package btpc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_TEMP_CAL   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HIGH = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LAST = 2'd3;

  localparam logic [23:0] SKIP_MARK  = 24'h800000;
  localparam logic [63:0] V1_OFFSET  = 64'd128000;
  localparam logic [63:0] P_BASE     = 64'd1048576;
  localparam logic [63:0] P_SCALE    = 64'd3125;
  localparam logic [63:0] P_ROUND    = 64'h0000_8000_0000_0000;

  localparam logic [1:0] PSTAT_OK   = 2'd0;
  localparam logic [1:0] PSTAT_SKIP = 2'd1;
  localparam logic [1:0] PSTAT_DIV0 = 2'd2;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction

endpackage

>>> hdl/btpc_mul.sv
// Shared multiplier: 64x64 wrapping product from one 32x32 multiplier over three partial products.
module btpc_mul
  import btpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic             done_o,
  output logic [DataW-1:0] prod_o
);

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;

  logic [DataW-1:0] a_q, b_q, acc_q;
  logic [1:0]       phase_q;
  logic             busy_q, done_q;
  logic [31:0]      op_a, op_b;
  logic [63:0]      pp;

  always_comb begin
    op_a = a_q[31:0];
    op_b = b_q[31:0];
    case (phase_q)
      PH_LH:   op_b = b_q[63:32];
      PH_HL:   op_a = a_q[63:32];
      default: ;
    endcase
    pp = 64'(op_a) * 64'(op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_LL;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= PH_LL;
      end else if (busy_q) begin
        case (phase_q)
          PH_LL:   phase_q <= PH_LH;
          PH_LH:   phase_q <= PH_HL;
          default: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (phase_q == PH_LL) acc_q <= pp;
      else acc_q <= acc_q + {pp[31:0], 32'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> hdl/btpc_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module btpc_div
  import btpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o
);

  logic [DataW-1:0] rem_q, quo_q, den_q;
  logic [6:0]       cnt_q;
  logic             busy_q, done_q, neg_q;
  logic [DataW:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_q, quo_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(DataW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[DataW-1] ? (~dividend_i + 64'd1) : dividend_i;
      den_q <= divisor_i[DataW-1] ? (~divisor_i + 64'd1) : divisor_i;
      neg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (!rem_sub[DataW]) begin
        rem_q <= rem_sub[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 64'd1) : quo_q;

endmodule

>>> hdl/baro_temp_press_compensation_unit.sv
// Top level: sequencer for temperature and pressure compensation over shared mul and div.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | raw_temperature_i, raw_pressure_i
//  out     | output    | out_valid_o/out_stall_i | temperature_centi_o, temperature_ok_o,
//          |           |                        | pressure_q24_8_o, pressure_status_o
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// A transaction runs through 14 multiplies (issue, three 32x32 partial products, done),
// the bit-serial divider, and accept, select and output steps.
// Skipped or zero-divisor readings finish early. Reset clears calibration and fine term.
// in_stall_o is high while a transaction is in work; a finished result waits in the output
// register until taken, and the next transaction may start meanwhile.
module baro_temp_press_compensation_unit
  import btpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [23:0]         raw_temperature_i,
  input  logic [23:0]         raw_pressure_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  temperature_centi_o,
  output logic                temperature_ok_o,
  output logic [31:0]         pressure_q24_8_o,
  output logic [1:0]          pressure_status_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DataW-1:0]    cfg_data_i
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_T1   = 5'd1;
  localparam logic [4:0] ST_T2   = 5'd2;
  localparam logic [4:0] ST_T3   = 5'd3;
  localparam logic [4:0] ST_T4   = 5'd4;
  localparam logic [4:0] ST_PSEL = 5'd5;
  localparam logic [4:0] ST_P5   = 5'd6;
  localparam logic [4:0] ST_P6   = 5'd7;
  localparam logic [4:0] ST_P7   = 5'd8;
  localparam logic [4:0] ST_P8   = 5'd9;
  localparam logic [4:0] ST_P9   = 5'd10;
  localparam logic [4:0] ST_P10  = 5'd11;
  localparam logic [4:0] ST_P11  = 5'd12;
  localparam logic [4:0] ST_DIV  = 5'd13;
  localparam logic [4:0] ST_P12  = 5'd14;
  localparam logic [4:0] ST_P13  = 5'd15;
  localparam logic [4:0] ST_P14  = 5'd16;
  localparam logic [4:0] ST_DONE = 5'd17;

  logic [47:0] tcal_q;
  logic [63:0] pcal_lo_q, pcal_hi_q;
  logic [15:0] pcal_last_q;
  logic [31:0] fine_q;

  logic [4:0]  state_q, state_d;
  logic        issued_q;
  logic [23:0] rt_q, rp_q;
  logic [31:0] ta_q, te_q, tc_q;
  logic        tok_q;
  logic [63:0] vv_q, v2_q, den_q, p_q, acc_q;
  logic [31:0] pres_q;
  logic [1:0]  pstat_q;

  logic        out_valid_q;
  logic [31:0] out_tc_q, out_pres_q;
  logic        out_tok_q;
  logic [1:0]  out_pstat_q;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_p, div_q;
  logic        in_acc, is_mul;

  logic [19:0] adc;
  logic [31:0] tx, td, m32, fine_new;
  logic [63:0] v1, num, ph, u_new, pfin;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign adc = rt_q[23:4];
  assign tx  = {15'b0, adc[19:3]} - {15'b0, tcal_q[15:0], 1'b0};
  assign td  = {16'b0, adc[19:4]} - {16'b0, tcal_q[15:0]};
  assign m32 = mul_p[31:0];
  assign fine_new = ta_q + 32'($signed(m32) >>> 14);
  assign v1  = {{32{fine_q[31]}}, fine_q} - V1_OFFSET;
  assign num = ((P_BASE - {44'b0, rp_q[23:4]}) << 31) - v2_q;
  assign ph  = 64'($signed(p_q) >>> 13);
  assign u_new = vv_q + (mul_p << 12);
  assign pfin = 64'($signed(acc_q + 64'($signed(mul_p) >>> 19)) >>> 8)
              + (sext16(pcal_hi_q[47:32]) << 4);

  always_comb begin
    is_mul = 1'b1;
    mul_a  = v1;
    mul_b  = v1;
    case (state_q)
      ST_T1:  begin mul_a = {32'b0, tx};     mul_b = sext16(tcal_q[31:16]); end
      ST_T2:  begin mul_a = {32'b0, td};     mul_b = {32'b0, td}; end
      ST_T3:  begin mul_a = {32'b0, te_q};   mul_b = sext16(tcal_q[47:32]); end
      ST_T4:  begin mul_a = {32'b0, fine_q}; mul_b = 64'd5; end
      ST_P5:  ;
      ST_P6:  begin mul_a = vv_q;     mul_b = sext16(pcal_hi_q[31:16]); end
      ST_P7:  begin mul_b = sext16(pcal_hi_q[15:0]); end
      ST_P8:  begin mul_a = vv_q;     mul_b = sext16(pcal_lo_q[47:32]); end
      ST_P9:  begin mul_b = sext16(pcal_lo_q[31:16]); end
      ST_P10: begin mul_a = P_ROUND + vv_q; mul_b = {48'b0, pcal_lo_q[15:0]}; end
      ST_P11: begin mul_a = num;      mul_b = P_SCALE; end
      ST_P12: begin mul_a = sext16(pcal_last_q); mul_b = ph; end
      ST_P13: begin mul_a = vv_q;     mul_b = ph; end
      ST_P14: begin mul_a = sext16(pcal_hi_q[63:48]); mul_b = p_q; end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !issued_q;
  assign div_start = (state_q == ST_DIV) && !issued_q;

  btpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  btpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (vv_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) begin
        state_d = (raw_temperature_i == SKIP_MARK) ? ST_PSEL : ST_T1;
      end
      ST_T1:  if (mul_done) state_d = ST_T2;
      ST_T2:  if (mul_done) state_d = ST_T3;
      ST_T3:  if (mul_done) state_d = ST_T4;
      ST_T4:  if (mul_done) state_d = ST_PSEL;
      ST_PSEL: state_d = (rp_q == SKIP_MARK) ? ST_DONE : ST_P5;
      ST_P5:  if (mul_done) state_d = ST_P6;
      ST_P6:  if (mul_done) state_d = ST_P7;
      ST_P7:  if (mul_done) state_d = ST_P8;
      ST_P8:  if (mul_done) state_d = ST_P9;
      ST_P9:  if (mul_done) state_d = ST_P10;
      ST_P10: if (mul_done) begin
        state_d = (64'($signed(mul_p) >>> 33) == '0) ? ST_DONE : ST_P11;
      end
      ST_P11: if (mul_done) state_d = ST_DIV;
      ST_DIV: if (div_done) state_d = ST_P12;
      ST_P12: if (mul_done) state_d = ST_P13;
      ST_P13: if (mul_done) state_d = ST_P14;
      ST_P14: if (mul_done) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      fine_q      <= '0;
      tcal_q      <= '0;
      pcal_lo_q   <= '0;
      pcal_hi_q   <= '0;
      pcal_last_q <= '0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) issued_q <= 1'b1;
      else if (mul_done || div_done) issued_q <= 1'b0;
      if (state_q == ST_T3 && mul_done) fine_q <= fine_new;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TEMP_CAL:   tcal_q      <= cfg_data_i[47:0];
          REG_PRESS_LOW:  pcal_lo_q   <= cfg_data_i;
          REG_PRESS_HIGH: pcal_hi_q   <= cfg_data_i;
          REG_PRESS_LAST: pcal_last_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rt_q    <= raw_temperature_i;
      rp_q    <= raw_pressure_i;
      tc_q    <= '0;
      tok_q   <= 1'b0;
      pres_q  <= '0;
      pstat_q <= PSTAT_OK;
    end
    if (state_q == ST_PSEL && rp_q == SKIP_MARK) pstat_q <= PSTAT_SKIP;
    if (mul_done) begin
      case (state_q)
        ST_T1:  ta_q <= 32'($signed(m32) >>> 11);
        ST_T2:  te_q <= 32'($signed(m32) >>> 12);
        ST_T4:  begin
          tc_q  <= 32'($signed(m32 + 32'd128) >>> 8);
          tok_q <= 1'b1;
        end
        ST_P5:  vv_q <= mul_p;
        ST_P6:  v2_q <= mul_p;
        ST_P7:  v2_q <= v2_q + (mul_p << 17) + (sext16(pcal_lo_q[63:48]) << 35);
        ST_P8:  vv_q <= 64'($signed(mul_p) >>> 8);
        ST_P9:  vv_q <= u_new;
        ST_P10: begin
          den_q <= 64'($signed(mul_p) >>> 33);
          if (64'($signed(mul_p) >>> 33) == '0) pstat_q <= PSTAT_DIV0;
        end
        ST_P11: vv_q <= mul_p;
        ST_P12: vv_q <= mul_p;
        ST_P13: acc_q <= p_q + 64'($signed(mul_p) >>> 25);
        ST_P14: pres_q <= pfin[31:0];
        default: ;
      endcase
    end
    if (state_q == ST_DIV && div_done) p_q <= div_q;
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_tc_q    <= tc_q;
      out_tok_q   <= tok_q;
      out_pres_q  <= pres_q;
      out_pstat_q <= pstat_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = out_tc_q;
  assign temperature_ok_o    = out_tok_q;
  assign pressure_q24_8_o    = out_pres_q;
  assign pressure_status_o   = out_pstat_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE) else $error("accepted transaction did not start");
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pressure_status_o != PSTAT_OK) |-> pressure_q24_8_o == '0)
    else $error("flagged pressure not zero");
  a_tskip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !temperature_ok_o) |-> temperature_centi_o == '0)
    else $error("skipped temperature not zero");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start)) else $error("mul and div started together");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the barometric temperature and pressure compensation unit.
`timescale 1ns / 1ps
module tb_top;
  import btpc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [23:0] raw_temperature_i = '0;
  logic [23:0] raw_pressure_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] temperature_centi_o;
  logic temperature_ok_o;
  logic [31:0] pressure_q24_8_o;
  logic [1:0] pressure_status_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;

  typedef struct packed {
    logic [23:0] raw_t;
    logic [23:0] raw_p;
  } reading_t;

  typedef struct packed {
    logic [31:0] centi;
    logic        t_ok;
    logic [31:0] press;
    logic [1:0]  pstat;
  } comp_t;

  reading_t pending_q[$];
  comp_t    expected_q[$];

  logic [47:0] cal_t;
  logic [63:0] cal_plo, cal_phi;
  logic [15:0] cal_p9;
  logic [31:0] fine_t;

  int errors = 0;
  int cycles = 0;
  bit src_quiet = 0;
  bit long_hold = 0;
  bit src_pause = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_cnt = 0;

  baro_temp_press_compensation_unit dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] s16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // advances the fine term and returns the compensated reading
  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic [31:0] adc, t1, t2, t3, a, d, b;
    logic [63:0] v1, v2, p, w1, w2;
    c = '0;
    if (r.raw_t != SKIP_MARK) begin
      adc = {12'd0, r.raw_t[23:4]};
      t1 = {16'd0, cal_t[15:0]};
      t2 = {{16{cal_t[31]}}, cal_t[31:16]};
      t3 = {{16{cal_t[47]}}, cal_t[47:32]};
      a = $signed(((adc >> 3) - (t1 << 1)) * t2) >>> 11;
      d = (adc >> 4) - t1;
      b = $signed(32'($signed(d * d) >>> 12) * t3) >>> 14;
      fine_t = a + b;
      c.centi = $signed(fine_t * 32'd5 + 32'd128) >>> 8;
      c.t_ok = 1'b1;
    end
    if (r.raw_p == SKIP_MARK) begin
      c.pstat = PSTAT_SKIP;
    end else begin
      v1 = {{32{fine_t[31]}}, fine_t} - V1_OFFSET;
      v2 = v1 * v1 * s16(cal_phi[31:16]);
      v2 = v2 + ((v1 * s16(cal_phi[15:0])) << 17);
      v2 = v2 + (s16(cal_plo[63:48]) << 35);
      v1 = 64'($signed(v1 * v1 * s16(cal_plo[47:32])) >>> 8)
           + ((v1 * s16(cal_plo[31:16])) << 12);
      v1 = $signed((P_ROUND + v1) * {48'd0, cal_plo[15:0]}) >>> 33;
      if (v1 == 0) begin
        c.pstat = PSTAT_DIV0;
      end else begin
        p = P_BASE - {44'd0, r.raw_p[23:4]};
        p = sdiv(((p << 31) - v2) * P_SCALE, v1);
        w1 = $signed(s16(cal_p9) * 64'($signed(p) >>> 13) * 64'($signed(p) >>> 13)) >>> 25;
        w2 = $signed(s16(cal_phi[63:48]) * p) >>> 19;
        p = 64'($signed(p + w1 + w2) >>> 8) + (s16(cal_phi[47:32]) << 4);
        c.press = p[31:0];
        c.pstat = PSTAT_OK;
      end
    end
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_q.push_back(compensate({raw_temperature_i, raw_pressure_i}));
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0 && !src_pause) begin
        if (!src_quiet && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(1, 9) - 1;
          in_valid_i <= 1'b0;
        end else begin
          {raw_temperature_i, raw_pressure_i} <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    comp_t exp_r;
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h %b %h %0d", $time,
                 temperature_centi_o, temperature_ok_o, pressure_q24_8_o, pressure_status_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.centi !== temperature_centi_o)
          $display("%0t temperature_centi: expected %h, actual %h", $time, exp_r.centi,
                   temperature_centi_o);
        if (exp_r.t_ok !== temperature_ok_o)
          $display("%0t temperature_ok: expected %b, actual %b", $time, exp_r.t_ok,
                   temperature_ok_o);
        if (exp_r.press !== pressure_q24_8_o)
          $display("%0t pressure_q24_8: expected %h, actual %h", $time, exp_r.press,
                   pressure_q24_8_o);
        if (exp_r.pstat !== pressure_status_o)
          $display("%0t pressure_status: expected %0d, actual %0d", $time, exp_r.pstat,
                   pressure_status_o);
        if (exp_r !== {temperature_centi_o, temperature_ok_o, pressure_q24_8_o,
                       pressure_status_o})
          errors++;
      end
    end
    if (long_hold) begin
      out_stall_i <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!src_quiet && $urandom_range(0, 6) == 0) begin
      sink_gap <= $urandom_range(1, 9) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("baro_temp_press_compensation_unit regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_TEMP_CAL:   cal_t = val[47:0];
      REG_PRESS_LOW:  cal_plo = val;
      REG_PRESS_HIGH: cal_phi = val;
      default:        cal_p9 = val[15:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // typical calibration with some jitter so the divisor stays nonzero
  task automatic load_typical();
    write_reg(REG_TEMP_CAL, 64'({16'd50, 16'd26435 + 16'($urandom_range(0, 2000)),
                                 16'd27504 + 16'($urandom_range(0, 2000))}));
    write_reg(REG_PRESS_LOW, {16'd2855, -16'sd2588 - 16'($urandom_range(0, 400)),
                              -16'sd10685, 16'd36477 + 16'($urandom_range(0, 4000))});
    write_reg(REG_PRESS_HIGH, {-16'sd7 - 16'($urandom_range(0, 9000)),
                               16'd9900 + 16'($urandom_range(0, 400)),
                               -16'sd7 - 16'($urandom_range(0, 20)),
                               16'd140 + 16'($urandom_range(0, 200))});
    write_reg(REG_PRESS_LAST, 64'(16'd6000 + 16'($urandom_range(0, 1000))));
  endtask

  function automatic logic [23:0] rnd_raw();
    case ($urandom_range(0, 9))
      0: return SKIP_MARK;
      1: return 24'($urandom);
      default: return 24'($urandom_range(24'h600000, 24'h880000));
    endcase
  endfunction

  initial begin
    cal_t = '0; cal_plo = '0; cal_phi = '0; cal_p9 = '0; fine_t = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // zero calibration: every non-skipped pressure hits the zero divisor
    pending_q.push_back({24'h000000, 24'h000000});
    pending_q.push_back({SKIP_MARK, SKIP_MARK});
    drain();
    load_typical();
    pending_q.push_back({24'h7FFFF0, 24'h4E3A00});
    pending_q.push_back({SKIP_MARK, 24'h4E3A00});
    pending_q.push_back({24'hFFFFFF, 24'hFFFFFF});
    pending_q.push_back({24'h000000, 24'h000000});
    pending_q.push_back({24'h800010, 24'h7FFFF0});
    pending_q.push_back({24'h555555, SKIP_MARK});
    pending_q.push_back({24'hAAAAAA, 24'hAAAAAA});
    drain();
    write_reg(REG_TEMP_CAL, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_LAST, 64'h8000);
    pending_q.push_back({24'hFFFFFF, 24'h000000});
    pending_q.push_back({24'h000000, 24'hFFFFFF});
    drain();
    write_reg(REG_TEMP_CAL, 64'h0000_7FFF_8000_FFFF);
    write_reg(REG_PRESS_LOW, 64'h7FFF_8000_7FFF_0001);
    write_reg(REG_PRESS_HIGH, 64'h8000_7FFF_8000_7FFF);
    write_reg(REG_PRESS_LAST, 64'h7FFF);
    pending_q.push_back({24'h123456, 24'h654321});
    pending_q.push_back({24'hFFFFFF, 24'hFFFFFF});
    drain();
    // long sink hold with the source still offering
    load_typical();
    long_hold = 1;
    repeat (10) pending_q.push_back({rnd_raw(), rnd_raw()});
    while (hold_cnt < 600) begin
      @(posedge clk_i);
      hold_cnt++;
    end
    long_hold = 0;
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        write_reg(REG_TEMP_CAL, {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_LOW, {$urandom, $urandom});
        write_reg(REG_PRESS_HIGH, {$urandom, $urandom});
        write_reg(REG_PRESS_LAST, 64'(16'($urandom)));
      end else begin
        load_typical();
      end
      if (ph == 6) src_quiet = 1;
      repeat (240) pending_q.push_back({rnd_raw(), rnd_raw()});
      if (ph == 1) begin
        while (pending_q.size() > 120) @(posedge clk_i);
        src_pause = 1;
        while (in_valid_i || expected_q.size() > 0) @(posedge clk_i);
        src_pause = 0;
      end
      drain();
    end
    if (errors == 0) begin
      $display("baro_temp_press_compensation_unit regression: pass");
    end else begin
      $display("baro_temp_press_compensation_unit regression: fail");
    end
    $finish;
  end

endmodule
